### hw/rtl/ebd_pkg.sv
// ----------------------------------------------------------------------------
// ebd_pkg
// shared widths, codes, control word layout and microcode table of the
// emergency brake decider
// ----------------------------------------------------------------------------
package ebd_pkg;

    localparam int RANGE_W     = 16;
    localparam int SPEED_W     = 16;
    localparam int GEAR_W      = 2;
    localparam int ACT_W       = 2;
    localparam int TTC_W       = 14;
    localparam int PERIOD_W    = 10;
    localparam int LIMIT_W     = 14;
    localparam int DIST_W      = 7;
    localparam int FACTOR_W    = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 14;
    localparam int PREV_W      = 7;
    localparam int DELTA_W     = PREV_W + 1;
    localparam int NUM_W       = 17;
    localparam int DEN_W       = 7;
    localparam int CMP_W       = LIMIT_W + DEN_W;
    localparam int CNT_W       = $clog2(NUM_W);
    localparam int PROD_W      = FACTOR_W + SPEED_W;
    localparam int ACC_W       = 14;
    localparam int PC_W        = 5;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 24;

    localparam int MAX_PULSE_LOOPS_DEF = 100;

    localparam logic [RANGE_W-1:0]  RANGE_LIMIT_CM  = 16'd80;
    localparam logic [NUM_W-1:0]    NO_TTC          = 17'd9999;
    localparam logic [CMP_W-1:0]    ABS_TTC_MS      = 21'd200;
    localparam logic [SPEED_W-1:0]  MIN_SPEED_CENTI = 16'd20;
    localparam logic [ACC_W-1:0]    LOOP_STEP       = 14'd100;
    localparam logic [2:0]          MOD5_LAST       = 3'd4;

    localparam logic [PERIOD_W-1:0] PERIOD_RST = 10'd10;
    localparam logic [LIMIT_W-1:0]  LIMIT_RST  = 14'd1000;
    localparam logic [DIST_W-1:0]   DIST_RST   = 7'd20;
    localparam logic [FACTOR_W-1:0] FACTOR_RST = 8'd10;

    localparam logic [GEAR_W-1:0] GEAR_IDLE  = 2'd0;
    localparam logic [GEAR_W-1:0] GEAR_DRIVE = 2'd1;
    localparam logic [GEAR_W-1:0] GEAR_BACK  = 2'd2;
    localparam logic [GEAR_W-1:0] GEAR_SPARE = 2'd3;

    typedef enum logic [ACT_W-1:0] {
        ACT_NONE    = 2'd0,
        ACT_STOP    = 2'd1,
        ACT_REVERSE = 2'd2
    } act_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PERIOD = 2'd0,
        CFG_LIMIT  = 2'd1,
        CFG_DIST   = 2'd2,
        CFG_FACTOR = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        UOP_NONE,
        UOP_ACCEPT,
        UOP_SETUP,
        UOP_CMP_LIMIT,
        UOP_DIV,
        UOP_CMP_ABS,
        UOP_PROD,
        UOP_SET_BRAKE,
        UOP_RELEASE,
        UOP_LOOP_INIT,
        UOP_LOOP_EMIT,
        UOP_EMIT
    } uop_t;

    typedef enum logic [3:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_INPUT,
        COND_IGNORED,
        COND_NOT_BRAKE,
        COND_STOP_ONE,
        COND_ABS_RUN,
        COND_STOP_NEAR,
        COND_DIV_MORE,
        COND_LOOP_MORE
    } cond_t;

    typedef struct packed {
        uop_t            op;
        act_t            act;
        logic            last;
        logic            upd_prev;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } ctrl_t;

    typedef struct packed {
        logic no_input;
        logic ignored;
        logic not_brake;
        logic stop_one;
        logic abs_run;
        logic stop_near;
        logic div_more;
        logic loop_more;
    } flags_t;

    // program step addresses
    localparam logic [PC_W-1:0] S_IDLE       = 5'd0;
    localparam logic [PC_W-1:0] S_CHECK      = 5'd1;
    localparam logic [PC_W-1:0] S_SETUP      = 5'd2;
    localparam logic [PC_W-1:0] S_CMP_LIMIT  = 5'd3;
    localparam logic [PC_W-1:0] S_DIV        = 5'd4;
    localparam logic [PC_W-1:0] S_CMP_ABS    = 5'd5;
    localparam logic [PC_W-1:0] S_PROD       = 5'd6;
    localparam logic [PC_W-1:0] S_DECIDE     = 5'd7;
    localparam logic [PC_W-1:0] S_BRAKE      = 5'd8;
    localparam logic [PC_W-1:0] S_TRY_ABS    = 5'd9;
    localparam logic [PC_W-1:0] S_TRY_NEAR   = 5'd10;
    localparam logic [PC_W-1:0] S_GO_NONE    = 5'd11;
    localparam logic [PC_W-1:0] S_LOOP_INIT  = 5'd12;
    localparam logic [PC_W-1:0] S_LOOP       = 5'd13;
    localparam logic [PC_W-1:0] S_STOP_LAST  = 5'd14;
    localparam logic [PC_W-1:0] S_RELEASE    = 5'd15;
    localparam logic [PC_W-1:0] S_NONE_LAST  = 5'd16;
    localparam logic [PC_W-1:0] S_IGNORE     = 5'd17;

    function automatic ctrl_t mk(input uop_t op, input act_t act, input logic last,
                                 input logic upd, input cond_t cond,
                                 input logic [PC_W-1:0] target);
        ctrl_t w;
        w.op       = op;
        w.act      = act;
        w.last     = last;
        w.upd_prev = upd;
        w.cond     = cond;
        w.target   = target;
        return w;
    endfunction

    function automatic ctrl_t ucode_rom(input logic [PC_W-1:0] pc);
        ctrl_t w;
        w = mk(UOP_NONE, ACT_NONE, 1'b0, 1'b0, COND_ALWAYS, S_IDLE);
        unique case (pc)
            S_IDLE:      w = mk(UOP_ACCEPT, ACT_NONE, 1'b0, 1'b0, COND_NO_INPUT, S_IDLE);
            S_CHECK:     w = mk(UOP_NONE, ACT_NONE, 1'b0, 1'b0, COND_IGNORED, S_IGNORE);
            S_SETUP:     w = mk(UOP_SETUP, ACT_NONE, 1'b0, 1'b0, COND_NEVER, S_IDLE);
            S_CMP_LIMIT: w = mk(UOP_CMP_LIMIT, ACT_NONE, 1'b0, 1'b0, COND_NEVER, S_IDLE);
            S_DIV:       w = mk(UOP_DIV, ACT_NONE, 1'b0, 1'b0, COND_DIV_MORE, S_DIV);
            S_CMP_ABS:   w = mk(UOP_CMP_ABS, ACT_NONE, 1'b0, 1'b0, COND_NEVER, S_IDLE);
            S_PROD:      w = mk(UOP_PROD, ACT_NONE, 1'b0, 1'b0, COND_NEVER, S_IDLE);
            S_DECIDE:    w = mk(UOP_NONE, ACT_NONE, 1'b0, 1'b0, COND_NOT_BRAKE, S_RELEASE);
            S_BRAKE:     w = mk(UOP_SET_BRAKE, ACT_NONE, 1'b0, 1'b0, COND_STOP_ONE,
                                S_STOP_LAST);
            S_TRY_ABS:   w = mk(UOP_NONE, ACT_NONE, 1'b0, 1'b0, COND_ABS_RUN, S_LOOP_INIT);
            S_TRY_NEAR:  w = mk(UOP_NONE, ACT_NONE, 1'b0, 1'b0, COND_STOP_NEAR, S_STOP_LAST);
            S_GO_NONE:   w = mk(UOP_NONE, ACT_NONE, 1'b0, 1'b0, COND_ALWAYS, S_NONE_LAST);
            S_LOOP_INIT: w = mk(UOP_LOOP_INIT, ACT_NONE, 1'b0, 1'b0, COND_NEVER, S_IDLE);
            S_LOOP:      w = mk(UOP_LOOP_EMIT, ACT_NONE, 1'b0, 1'b0, COND_LOOP_MORE, S_LOOP);
            S_STOP_LAST: w = mk(UOP_EMIT, ACT_STOP, 1'b1, 1'b1, COND_ALWAYS, S_IDLE);
            S_RELEASE:   w = mk(UOP_RELEASE, ACT_NONE, 1'b0, 1'b0, COND_NEVER, S_IDLE);
            S_NONE_LAST: w = mk(UOP_EMIT, ACT_NONE, 1'b1, 1'b1, COND_ALWAYS, S_IDLE);
            S_IGNORE:    w = mk(UOP_EMIT, ACT_NONE, 1'b1, 1'b0, COND_ALWAYS, S_IDLE);
            default:     w = mk(UOP_NONE, ACT_NONE, 1'b0, 1'b0, COND_ALWAYS, S_IDLE);
        endcase
        return w;
    endfunction

endpackage

### hw/rtl/ebd_sequencer.sv
// ----------------------------------------------------------------------------
// ebd_sequencer
// step counter over the microcode table with conditional jumps
// ----------------------------------------------------------------------------
module ebd_sequencer (
    input  logic            clk,
    input  logic            rst_n,
    input  ebd_pkg::flags_t flags,
    input  logic            stall,
    output ebd_pkg::ctrl_t  ctrl
);
    import ebd_pkg::*;

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic            taken;

    assign ctrl = ucode_rom(pc_reg);

    always_comb
    begin
        unique case (ctrl.cond)
            COND_NEVER:     taken = 1'b0;
            COND_ALWAYS:    taken = 1'b1;
            COND_NO_INPUT:  taken = flags.no_input;
            COND_IGNORED:   taken = flags.ignored;
            COND_NOT_BRAKE: taken = flags.not_brake;
            COND_STOP_ONE:  taken = flags.stop_one;
            COND_ABS_RUN:   taken = flags.abs_run;
            COND_STOP_NEAR: taken = flags.stop_near;
            COND_DIV_MORE:  taken = flags.div_more;
            COND_LOOP_MORE: taken = flags.loop_more;
            default:        taken = 1'b1;
        endcase
        priority if (stall)
            pc_next = pc_reg;
        else if (taken)
            pc_next = ctrl.target;
        else
            pc_next = pc_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= S_IDLE;
        else
            pc_reg <= pc_next;
    end

endmodule

### hw/rtl/ttc_emergency_brake_decider_top.sv
// ----------------------------------------------------------------------------
// ttc_emergency_brake_decider_top
// range-sample driven emergency brake decider with time-to-collision check
// and abs pulse runs, controlled by a microcoded sequencer
//
//   channel   dir  handshake           contents
//   s_*       in   s_tvalid/s_tready   range_cm, speed_centi, gear
//   m_*       out  m_tvalid/m_tready   motor_action, brake_flag, ttc_ms; tlast
//   cfg_*     in   cfg_we              register index and data, no read-back
//
// an ignored sample skips the ttc work; any other sample goes through the
// 17-step one-bit-a-cycle ttc divider, and an abs run then loops up to
// MAX_PULSE_LOOPS times in the loop step of the program
// one request is worked at a time; the next is taken once the last result
// sits in the output register, which holds while m_tready is low
// rst_n is asynchronous and restores register defaults and the state
// ----------------------------------------------------------------------------
module ttc_emergency_brake_decider_top #(
    parameter int MAX_PULSE_LOOPS = ebd_pkg::MAX_PULSE_LOOPS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // range_cm[15:0], speed_centi[31:16], gear[33:32], zero pad
    input  logic [ebd_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // motor_action[1:0], brake_flag[2], ttc_ms[16:3], zero pad
    output logic [ebd_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic                               m_tlast,
    input  logic                               cfg_we,
    input  logic [ebd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ebd_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import ebd_pkg::*;

    localparam int PCAP_MAX = MAX_PULSE_LOOPS * 100;
    localparam int OUT_PAD  = OUT_TDATA_W - ACT_W - 1 - TTC_W;

    ctrl_t  ctrl;
    flags_t flags;
    logic   stall;

    logic [PERIOD_W-1:0] period_reg;
    logic [LIMIT_W-1:0]  limit_reg;
    logic [DIST_W-1:0]   dist_reg;
    logic [FACTOR_W-1:0] factor_reg;

    logic [PREV_W-1:0]   prev_reg;
    logic                brake_reg;
    logic [TTC_W-1:0]    held_reg;

    logic [PREV_W-1:0]   sample_reg;
    logic                over_reg;
    logic [SPEED_W-1:0]  speed_reg;
    logic [GEAR_W-1:0]   gear_reg;
    logic [NUM_W-1:0]    num_reg;
    logic [DEN_W-1:0]    den_reg;
    logic [NUM_W-1:0]    quo_reg;
    logic [DEN_W-1:0]    rem_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                lt_reg;
    logic                gt_reg;
    logic                ge_reg;
    logic [ACC_W-1:0]    pcap_reg;
    logic [ACC_W-1:0]    acc_reg;
    logic                even_reg;
    logic [2:0]          mod5_reg;

    logic                out_valid_reg;
    act_t                out_act_reg;
    logic                out_brake_reg;
    logic [TTC_W-1:0]    out_ttc_reg;
    logic                out_last_reg;

    logic [DELTA_W-1:0]  delta;
    logic [ACC_W-1:0]    delta_x100;
    logic                ttc_ok;
    logic [NUM_W-1:0]    range_x_period;
    logic [CMP_W-1:0]    limit_x_den;
    logic [CMP_W-1:0]    abs_x_den;
    logic [PROD_W-1:0]   speed_prod;
    logic [DEN_W:0]      rem_sh;
    logic                rem_ge;
    logic                accept;
    logic                emit_req;
    act_t                emit_act;
    logic                emit_last;
    logic                out_load;
    logic                advance;

    ebd_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .stall (stall),
        .ctrl  (ctrl)
    );

    assign s_tready = (ctrl.op == UOP_ACCEPT);
    assign accept   = s_tvalid && s_tready;

    // closing delta and ttc operands
    assign delta          = {1'b0, prev_reg} - {1'b0, sample_reg};
    assign delta_x100     = ACC_W'(delta[PREV_W-1:0]) * LOOP_STEP;
    assign ttc_ok         = !delta[DELTA_W-1] && (delta[PREV_W-1:0] > 7'd1)
                            && (delta_x100 > ACC_W'(period_reg));
    assign range_x_period = NUM_W'(sample_reg) * NUM_W'(period_reg);
    assign limit_x_den    = CMP_W'(limit_reg) * CMP_W'(den_reg);
    assign abs_x_den      = ABS_TTC_MS * CMP_W'(den_reg);
    assign speed_prod     = PROD_W'(factor_reg) * PROD_W'(speed_reg);

    // restoring divider step
    assign rem_sh = {rem_reg, quo_reg[NUM_W-1]};
    assign rem_ge = (rem_sh >= {1'b0, den_reg});

    assign flags.no_input  = !s_tvalid;
    assign flags.ignored   = over_reg;
    assign flags.not_brake = !((gear_reg != GEAR_BACK)
                               && (lt_reg || (sample_reg < dist_reg)));
    assign flags.stop_one  = lt_reg && ge_reg;
    assign flags.abs_run   = !ge_reg && (sample_reg > dist_reg)
                             && (speed_reg >= MIN_SPEED_CENTI);
    assign flags.stop_near = (sample_reg <= dist_reg) && (gear_reg != GEAR_IDLE);
    assign flags.div_more  = (cnt_reg != '0);
    assign flags.loop_more = (acc_reg <= pcap_reg);

    always_comb
    begin
        emit_req  = 1'b0;
        emit_act  = ctrl.act;
        emit_last = ctrl.last;
        unique case (ctrl.op)
            UOP_EMIT:
            begin
                emit_req = 1'b1;
            end
            UOP_LOOP_EMIT:
            begin
                emit_req  = flags.loop_more && (even_reg || (mod5_reg == '0));
                emit_act  = even_reg ? ACT_REVERSE : ACT_STOP;
                emit_last = 1'b0;
            end
            default:
            begin
                emit_req = 1'b0;
            end
        endcase
    end

    assign out_load = emit_req && (!out_valid_reg || m_tready);
    assign stall    = emit_req && !out_load;
    assign advance  = !stall;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RST;
            limit_reg  <= LIMIT_RST;
            dist_reg   <= DIST_RST;
            factor_reg <= FACTOR_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_PERIOD: period_reg <= cfg_data[PERIOD_W-1:0];
                CFG_LIMIT:  limit_reg  <= cfg_data[LIMIT_W-1:0];
                CFG_DIST:   dist_reg   <= cfg_data[DIST_W-1:0];
                CFG_FACTOR: factor_reg <= cfg_data[FACTOR_W-1:0];
                default:    period_reg <= period_reg;
            endcase
        end
    end

    // state kept between samples
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg  <= '0;
            brake_reg <= 1'b0;
            held_reg  <= TTC_W'(NO_TTC);
        end
        else
        begin
            if (ctrl.op == UOP_CMP_ABS)
                held_reg <= quo_reg[TTC_W-1:0];
            if (ctrl.op == UOP_SET_BRAKE)
                brake_reg <= 1'b1;
            else if (ctrl.op == UOP_RELEASE && gt_reg && (sample_reg > dist_reg))
                brake_reg <= 1'b0;
            if (out_load && ctrl.upd_prev)
                prev_reg <= sample_reg;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= s_tdata[PREV_W-1:0];
            over_reg   <= (s_tdata[RANGE_W-1:0] > RANGE_LIMIT_CM);
            speed_reg  <= s_tdata[RANGE_W +: SPEED_W];
            gear_reg   <= s_tdata[RANGE_W + SPEED_W +: GEAR_W];
        end
        unique case (ctrl.op)
            UOP_SETUP:
            begin
                num_reg <= ttc_ok ? range_x_period : NO_TTC;
                den_reg <= ttc_ok ? delta[DEN_W-1:0] : DEN_W'(1);
            end
            UOP_CMP_LIMIT:
            begin
                lt_reg  <= (CMP_W'(num_reg) < limit_x_den);
                gt_reg  <= (CMP_W'(num_reg) > limit_x_den);
                quo_reg <= num_reg;
                rem_reg <= '0;
                cnt_reg <= CNT_W'(NUM_W - 1);
            end
            UOP_DIV:
            begin
                quo_reg <= {quo_reg[NUM_W-2:0], rem_ge};
                rem_reg <= rem_ge ? DEN_W'(rem_sh - {1'b0, den_reg}) : rem_sh[DEN_W-1:0];
                cnt_reg <= cnt_reg - 1'b1;
            end
            UOP_CMP_ABS:
            begin
                ge_reg <= (CMP_W'(num_reg) >= abs_x_den);
            end
            UOP_PROD:
            begin
                pcap_reg <= (speed_prod >= PROD_W'(PCAP_MAX)) ? ACC_W'(PCAP_MAX)
                                                              : speed_prod[ACC_W-1:0];
            end
            UOP_LOOP_INIT:
            begin
                acc_reg  <= LOOP_STEP;
                even_reg <= 1'b0;
                mod5_reg <= 3'd1;
            end
            UOP_LOOP_EMIT:
            begin
                if (advance && flags.loop_more)
                begin
                    acc_reg  <= acc_reg + LOOP_STEP;
                    even_reg <= !even_reg;
                    mod5_reg <= (mod5_reg == MOD5_LAST) ? 3'd0 : mod5_reg + 3'd1;
                end
            end
            default:
            begin
                cnt_reg <= cnt_reg;
            end
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_act_reg   <= emit_act;
            out_brake_reg <= brake_reg;
            out_ttc_reg   <= held_reg;
            out_last_reg  <= emit_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{OUT_PAD{1'b0}}, out_ttc_reg, out_brake_reg, out_act_reg};

endmodule

### hw/rtl/ebd_checker.sv
// ----------------------------------------------------------------------------
// ebd_checker
// port-level checks of the emergency brake decider, bound to the top level
// ----------------------------------------------------------------------------
module ebd_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [ebd_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic                            m_tlast
);
    import ebd_pkg::*;

    // one request at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request taken while previous one still in work");

    // idle only once the final result of a request is out
    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tready && m_tvalid) |-> m_tlast)
        else $error("ready for a request with a run still open");

    // only abs runs give results before the last, and they brake
    a_run_brakes: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tlast) |-> m_tdata[ACT_W])
        else $error("open run without brake flag");

    a_action_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[ACT_W-1:0] == ACT_NONE) || (m_tdata[ACT_W-1:0] == ACT_STOP)
                      || (m_tdata[ACT_W-1:0] == ACT_REVERSE)))
        else $error("undefined motor action");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled result changed");

endmodule

bind ttc_emergency_brake_decider_top ebd_checker u_ebd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

### bench/ttc_emergency_brake_decider_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttc_emergency_brake_decider_top_tb
// self-checking bench for the emergency brake decider: directed and random
// range samples go in on the s_ stream, a scoreboard predicts the motor
// commands, brake flag and time to collision of every request and checks
// each command on the m_ stream in order, over several register settings
// ----------------------------------------------------------------------------
module ttc_emergency_brake_decider_top_tb;
    import ebd_pkg::*;

    typedef struct packed {
        act_t              action;
        logic              flag;
        logic [TTC_W-1:0]  ttc;
        logic              last;
    } brake_cmd_t;

    class brake_scoreboard;
        logic [PERIOD_W-1:0] period;
        logic [LIMIT_W-1:0]  limit;
        logic [DIST_W-1:0]   brake_dist;
        logic [FACTOR_W-1:0] factor;
        logic [PREV_W-1:0]   prev_range;
        logic                brake_on;
        logic [TTC_W-1:0]    held_ttc;
        brake_cmd_t          expected_cmds[$];
        int                  errors;

        function new();
            period     = PERIOD_RST;
            limit      = LIMIT_RST;
            brake_dist = DIST_RST;
            factor     = FACTOR_RST;
            prev_range = '0;
            brake_on   = 1'b0;
            held_ttc   = TTC_W'(NO_TTC);
            errors     = 0;
        endfunction

        function int outstanding();
            return expected_cmds.size();
        endfunction

        function void apply_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_PERIOD: period     = val[PERIOD_W-1:0];
                CFG_LIMIT:  limit      = val[LIMIT_W-1:0];
                CFG_DIST:   brake_dist = val[DIST_W-1:0];
                CFG_FACTOR: factor     = val[FACTOR_W-1:0];
                default:    ;
            endcase
        endfunction

        function void push_cmd(act_t action, logic last);
            brake_cmd_t c;
            c.action = action;
            c.flag   = brake_on;
            c.ttc    = held_ttc;
            c.last   = last;
            expected_cmds.push_back(c);
        endfunction

        // brake decision for one accepted range sample
        function void note_request(logic [RANGE_W-1:0] sample_cm,
                                   logic [SPEED_W-1:0] speed,
                                   logic [GEAR_W-1:0] gear);
            int              delta;
            longint unsigned num;
            longint unsigned den;
            longint unsigned loops;
            bit              lt_limit;
            bit              gt_limit;
            bit              ge_abs;
            if (sample_cm > RANGE_LIMIT_CM)
            begin
                push_cmd(ACT_NONE, 1'b1);
                return;
            end
            delta = int'(prev_range) - int'(sample_cm);
            if (delta > 1 && delta * 100 > int'(period))
            begin
                num = 64'(sample_cm) * 64'(period);
                den = 64'(delta);
            end
            else
            begin
                num = 64'(NO_TTC);
                den = 1;
            end
            held_ttc = TTC_W'(num / den);
            lt_limit = num < 64'(limit) * den;
            gt_limit = num > 64'(limit) * den;
            ge_abs   = num >= 64'(ABS_TTC_MS) * den;

            if (gear != GEAR_BACK && (lt_limit || sample_cm < brake_dist))
            begin
                brake_on = 1'b1;
                if (lt_limit && ge_abs)
                begin
                    push_cmd(ACT_STOP, 1'b1);
                end
                else if (!ge_abs && sample_cm > brake_dist && speed >= MIN_SPEED_CENTI)
                begin
                    loops = (64'(factor) * 64'(speed)) / 100;
                    if (loops > MAX_PULSE_LOOPS_DEF)
                        loops = MAX_PULSE_LOOPS_DEF;
                    for (int i = 1; i <= int'(loops); i++)
                    begin
                        if (i % 2 == 0)
                            push_cmd(ACT_REVERSE, 1'b0);
                        else if (i % 5 == 0)
                            push_cmd(ACT_STOP, 1'b0);
                    end
                    push_cmd(ACT_STOP, 1'b1);
                end
                else if (sample_cm <= brake_dist && gear != GEAR_IDLE)
                begin
                    push_cmd(ACT_STOP, 1'b1);
                end
                else
                begin
                    push_cmd(ACT_NONE, 1'b1);
                end
            end
            else
            begin
                if (gt_limit && sample_cm > brake_dist)
                    brake_on = 1'b0;
                push_cmd(ACT_NONE, 1'b1);
            end
            prev_range = sample_cm[PREV_W-1:0];
        endfunction

        task report(string what);
            errors++;
            $display("[%0t] mismatch: %s", $time, what);
        endtask

        task check_result(logic [OUT_TDATA_W-1:0] data, logic tlast);
            brake_cmd_t want;
            if (expected_cmds.size() == 0)
            begin
                report($sformatf("command %h arrived with none expected", data));
                return;
            end
            want = expected_cmds.pop_front();
            if (data[1:0] != want.action)
                report($sformatf("motor_action %0d, expected %0d", data[1:0], want.action));
            if (data[2] != want.flag)
                report($sformatf("brake_flag %0d, expected %0d", data[2], want.flag));
            if (data[16:3] != want.ttc)
                report($sformatf("ttc_ms %0d, expected %0d", data[16:3], want.ttc));
            if (tlast != want.last)
                report($sformatf("tlast %0d, expected %0d", tlast, want.last));
        endtask
    endclass

    localparam int CYCLE_LIMIT = 1500000;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;
    logic                   cfg_we;
    cfg_idx_t               cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    brake_scoreboard   sb;
    bit                idle_on;
    int                stall_left = 0;
    int                cycles = 0;
    logic [PREV_W-1:0] last_range;

    ttc_emergency_brake_decider_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver back-pressure in random bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
            stall_left--;
        else if (idle_on && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 15);
        m_tready <= (stall_left == 0);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tlast);
    end

    task automatic send_sample(input logic [RANGE_W-1:0] sample_cm,
                               input logic [SPEED_W-1:0] speed,
                               input logic [GEAR_W-1:0] gear);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, gear, speed, sample_cm};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_request(sample_cm, speed, gear);
        if (sample_cm <= RANGE_LIMIT_CM)
            last_range = sample_cm[PREV_W-1:0];
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_regs(input logic [CFG_DATA_W-1:0] period,
                              input logic [CFG_DATA_W-1:0] limit,
                              input logic [CFG_DATA_W-1:0] brake_dist,
                              input logic [CFG_DATA_W-1:0] factor);
        cfg_idx_t              regs[4] = '{CFG_PERIOD, CFG_LIMIT, CFG_DIST, CFG_FACTOR};
        logic [CFG_DATA_W-1:0] vals[4];
        vals = '{period, limit, brake_dist, factor};
        for (int i = 0; i < 4; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            @(posedge clk);
            sb.apply_reg(regs[i], vals[i]);
        end
        cfg_we <= 1'b0;
    endtask

    // mostly approaching obstacles, with jumps, restarts and out-of-range noise
    task automatic random_samples(input int count);
        int                   taken;
        int                   pick;
        int                   step;
        logic [RANGE_W-1:0]   sample_cm;
        logic [SPEED_W-1:0]   speed;
        logic [GEAR_W-1:0]    gear;
        taken = 0;
        while (taken < count)
        begin
            pick = $urandom_range(0, 99);
            step = $urandom_range(0, 12);
            if (pick < 12)
                sample_cm = RANGE_W'($urandom_range(81, 65535));
            else if (pick < 65)
                sample_cm = (last_range > step) ? RANGE_W'(last_range - step) : '0;
            else if (pick < 82)
                sample_cm = RANGE_W'($urandom_range(0, 80));
            else
                sample_cm = RANGE_W'($urandom_range(60, 80));

            pick = $urandom_range(0, 9);
            if (pick == 0)
                speed = SPEED_W'($urandom_range(0, 65535));
            else if (pick < 3)
                speed = SPEED_W'($urandom_range(0, 19));
            else
                speed = SPEED_W'($urandom_range(20, 1200));

            pick = $urandom_range(0, 9);
            if (pick == 0)
                gear = GEAR_IDLE;
            else if (pick == 1)
                gear = GEAR_BACK;
            else if (pick == 2)
                gear = GEAR_SPARE;
            else
                gear = GEAR_DRIVE;

            send_sample(sample_cm, speed, gear);
            if (sample_cm <= RANGE_LIMIT_CM)
                taken++;
        end
    endtask

    initial
    begin
        sb         = new();
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_PERIOD;
        cfg_data   = '0;
        idle_on    = 1'b1;
        last_range = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // register defaults after reset
        send_sample(16'hFFFF, 16'hFFFF, GEAR_SPARE);
        send_sample(16'd81, 16'd100, GEAR_DRIVE);
        send_sample(16'd80, 16'd0, GEAR_DRIVE);
        send_sample(16'd60, 16'd500, GEAR_DRIVE);
        send_sample(16'd50, 16'd19, GEAR_DRIVE);
        send_sample(16'd45, 16'd300, GEAR_BACK);
        send_sample(16'd44, 16'd300, GEAR_DRIVE);
        send_sample(16'd80, 16'd300, GEAR_DRIVE);
        send_sample(16'd78, 16'd100, GEAR_DRIVE);
        send_sample(16'd19, 16'd100, GEAR_IDLE);
        send_sample(16'd20, 16'd100, GEAR_DRIVE);
        send_sample(16'd10, 16'd100, GEAR_DRIVE);
        send_sample(16'd0, 16'd100, GEAR_SPARE);
        send_sample(16'd0, 16'hFFFF, GEAR_BACK);
        send_sample(16'd80, 16'hFFFF, GEAR_DRIVE);
        send_sample(16'd40, 16'hFFFF, GEAR_SPARE);
        send_sample(16'd80, 16'd0, GEAR_IDLE);
        send_sample(16'd79, 16'd0, GEAR_DRIVE);
        send_sample(16'd80, 16'd0, GEAR_DRIVE);
        wait_drain();

        // upper extremes
        write_regs(14'd1000, 14'd9999, 14'd80, 14'd255);
        send_sample(16'd69, 16'd1000, GEAR_DRIVE);
        send_sample(16'd59, 16'd1000, GEAR_DRIVE);
        random_samples(30);
        wait_drain();

        // lower extremes, period zero included
        write_regs(14'd0, 14'd0, 14'd0, 14'd0);
        send_sample(16'd80, 16'd500, GEAR_DRIVE);
        send_sample(16'd70, 16'd500, GEAR_DRIVE);
        random_samples(25);
        wait_drain();

        for (int phase = 0; phase < 5; phase++)
        begin
            idle_on = (phase == 4) ? 1'b0 : ($urandom_range(0, 3) != 0);
            write_regs(CFG_DATA_W'($urandom_range(1, 1000)),
                       ($urandom_range(0, 1) == 0) ? CFG_DATA_W'($urandom_range(0, 9999))
                                                   : CFG_DATA_W'($urandom_range(150, 2500)),
                       CFG_DATA_W'($urandom_range(0, 80)),
                       CFG_DATA_W'($urandom_range(0, 255)));
            random_samples(30);
            wait_drain();
        end

        repeat (40) @(posedge clk);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/ebd_pkg.sv
hw/rtl/ebd_sequencer.sv
hw/rtl/ttc_emergency_brake_decider_top.sv
hw/rtl/ebd_checker.sv
bench/ttc_emergency_brake_decider_top_tb.sv
